FILE: hw/rtl/ssdtm_pkg.sv
// Shared constants and types for the SSD template match unit.
`default_nettype none

package ssdtm_pkg;

    localparam int MAX_IMAGE_WIDTH   = 1024;
    localparam int MAX_IMAGE_HEIGHT  = 1024;
    localparam int MAX_TEMPLATE_SIDE = 16;

    localparam int PIX_W      = 8;
    localparam int SQ_W       = 16;
    localparam int SCORE_W    = 24;
    localparam int POS_W      = 10;
    localparam int ROW_W      = 10;
    localparam int IMG_REG_W  = 11;
    localparam int TPL_REG_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH     = 2'd0,
        REG_IMAGE_HEIGHT    = 2'd1,
        REG_TEMPLATE_WIDTH  = 2'd2,
        REG_TEMPLATE_HEIGHT = 2'd3
    } cfg_reg_t;

    localparam logic OP_LOAD_TEMPLATE = 1'b0;
    localparam logic OP_IMAGE_PIXEL   = 1'b1;

    typedef struct packed {
        logic win_shift;
        logic tmpl_we;
        logic mac_clear;
        logic mac_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ssdtm_line_buf.sv
// Line buffer memory: one word per column, one byte lane per buffered row.
`default_nettype none

module ssdtm_line_buf #(
    parameter int SIDE  = ssdtm_pkg::MAX_TEMPLATE_SIDE,
    parameter int MAX_W = ssdtm_pkg::MAX_IMAGE_WIDTH
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [$clog2(MAX_W)-1:0]              wr_col,
    input  wire logic [(SIDE > 1 ? $clog2(SIDE) : 1)-1:0] wr_lane,
    input  wire logic [ssdtm_pkg::PIX_W-1:0]           wr_data,
    input  wire logic [$clog2(MAX_W)-1:0]              rd_col,
    output logic      [SIDE*ssdtm_pkg::PIX_W-1:0]      rd_word
);

    localparam int PW = ssdtm_pkg::PIX_W;

    logic [SIDE*PW-1:0] mem_reg [MAX_W];
    logic [SIDE*PW-1:0] rd_word_reg;

    // Write one byte lane, read a whole column
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_col][32'(wr_lane)*PW +: PW] <= wr_data;
        end
        rd_word_reg <= mem_reg[rd_col];
    end

    assign rd_word = rd_word_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ssdtm_tmpl_mem.sv
// Flat template store in raster order, one write and one read port.
`default_nettype none

module ssdtm_tmpl_mem #(
    parameter int SIDE = ssdtm_pkg::MAX_TEMPLATE_SIDE
) (
    input  wire logic                              aclk,
    input  wire logic                              wr_en,
    input  wire logic [$clog2(SIDE*SIDE)-1:0]      wr_addr,
    input  wire logic [ssdtm_pkg::PIX_W-1:0]       wr_data,
    input  wire logic [$clog2(SIDE*SIDE)-1:0]      rd_addr,
    output logic      [ssdtm_pkg::PIX_W-1:0]       rd_data
);

    logic [ssdtm_pkg::PIX_W-1:0] mem_reg [SIDE*SIDE];
    logic [ssdtm_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ssdtm_cell.sv
// One window row: shifting pixels, template row, squared-difference MAC, chain adder.
`default_nettype none

module ssdtm_cell #(
    parameter int SIDE     = ssdtm_pkg::MAX_TEMPLATE_SIDE,
    parameter int CELL_IDX = 0
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire ssdtm_pkg::cell_ctrl_t                       ctrl,
    input  wire logic [SIDE*ssdtm_pkg::PIX_W-1:0]            lb_word,
    input  wire logic [(SIDE > 1 ? $clog2(SIDE) : 1)-1:0]    lrow,
    input  wire logic [$clog2(SIDE+1)-1:0]                   tw,
    input  wire logic [$clog2(SIDE+1)-1:0]                   th,
    input  wire logic [(SIDE > 1 ? $clog2(SIDE) : 1)-1:0]    tmpl_col,
    input  wire logic [(SIDE > 1 ? $clog2(SIDE) : 1)-1:0]    tmpl_row,
    input  wire logic [ssdtm_pkg::PIX_W-1:0]                 tmpl_data,
    input  wire logic [(SIDE > 1 ? $clog2(SIDE) : 1)-1:0]    mac_x,
    input  wire logic [ssdtm_pkg::SQ_W+$clog2(SIDE*SIDE):0]  acc_in,
    output logic      [ssdtm_pkg::SQ_W+$clog2(SIDE*SIDE):0]  acc_out
);

    localparam int PW    = ssdtm_pkg::PIX_W;
    localparam int SW    = ssdtm_pkg::SQ_W;
    localparam int L_W   = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int RS_W  = SW + $clog2(SIDE) + 1;
    localparam int ACC_W = SW + $clog2(SIDE*SIDE) + 1;

    logic [PW-1:0]    win_reg  [SIDE];
    logic [PW-1:0]    tmpl_reg [SIDE];
    logic [SW-1:0]    sq_reg;
    logic             sq_vld_reg;
    logic [RS_W-1:0]  row_sum_reg;
    logic [ACC_W-1:0] acc_reg;

    logic [31:0]        src_sum;
    logic [31:0]        src_wrap;
    logic [L_W-1:0]     src;
    logic               row_on;
    logic [PW-1:0]      new_px;
    logic [31:0]        wpos;
    logic [PW-1:0]      win_px;
    logic [PW-1:0]      tpl_px;
    logic signed [PW:0] diff;
    logic signed [2*PW+1:0] prod;
    logic [SW-1:0]      sq_next;

    // Pick the buffered row that feeds this window row
    always_comb begin
        src_sum = 32'(lrow) + 32'(SIDE + 1 + CELL_IDX) - 32'(th);
        if (src_sum >= 32'(2*SIDE)) begin
            src_wrap = src_sum - 32'(2*SIDE);
        end else if (src_sum >= 32'(SIDE)) begin
            src_wrap = src_sum - 32'(SIDE);
        end else begin
            src_wrap = src_sum;
        end
        src    = src_wrap[L_W-1:0];
        row_on = 32'(CELL_IDX) < 32'(th);
        new_px = row_on ? lb_word[32'(src)*PW +: PW] : '0;
    end

    // Squared difference of one window column against the template
    always_comb begin
        wpos    = 32'(SIDE) - 32'(tw) + 32'(mac_x);
        win_px  = win_reg[wpos[L_W-1:0]];
        tpl_px  = tmpl_reg[mac_x];
        diff    = $signed({1'b0, win_px}) - $signed({1'b0, tpl_px});
        prod    = diff * diff;
        sq_next = prod[SW-1:0];
    end

    // Shift window, load template row, accumulate
    always_ff @(posedge aclk) begin
        if (ctrl.win_shift) begin
            for (int i = 0; i < SIDE - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[SIDE-1] <= new_px;
        end
        if (ctrl.tmpl_we && (32'(tmpl_row) == 32'(CELL_IDX))) begin
            tmpl_reg[tmpl_col] <= tmpl_data;
        end
        if (ctrl.mac_en) begin
            sq_reg <= sq_next;
        end
        if (ctrl.mac_clear) begin
            row_sum_reg <= '0;
        end else if (sq_vld_reg) begin
            row_sum_reg <= row_sum_reg + RS_W'(sq_reg);
        end
        acc_reg <= acc_in + (row_on ? ACC_W'(row_sum_reg) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
        end else begin
            sq_vld_reg <= ctrl.mac_en;
        end
    end

    assign acc_out = acc_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ssd_template_match_unit.sv
// SSD template match unit: a row of window cells scores each image pixel.
// Sequence: a template load item goes to the flat template store; an image item is
// written to the line buffer, read back and shifted into the cells; when it closes a window,
// its score comes from the tw-step multiply loop in each cell and the registered adder chain.
// After a template load or register write, the next image item first loads the cells.
// One item in flight at a time. Reset: synchronous, active low; registers 1024, 1024, 16, 16.
`default_nettype none

module ssd_template_match_unit #(
    parameter int MAX_IMAGE_WIDTH   = ssdtm_pkg::MAX_IMAGE_WIDTH,
    parameter int MAX_TEMPLATE_SIDE = ssdtm_pkg::MAX_TEMPLATE_SIDE
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_op,
    input  wire logic [ssdtm_pkg::PIX_W-1:0]         s_pixel,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [ssdtm_pkg::SCORE_W-1:0]       m_score,
    output logic      [ssdtm_pkg::POS_W-1:0]         m_win_row,
    output logic      [ssdtm_pkg::POS_W-1:0]         m_win_col,
    output logic                                     m_last,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ssdtm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ssdtm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int SIDE  = MAX_TEMPLATE_SIDE;
    localparam int PW    = ssdtm_pkg::PIX_W;
    localparam int L_W   = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int TS_W  = $clog2(SIDE + 1);
    localparam int TA_W  = $clog2(SIDE * SIDE);
    localparam int N_W   = $clog2(SIDE * SIDE + 1);
    localparam int C_W   = $clog2(MAX_IMAGE_WIDTH);
    localparam int W_W   = $clog2(MAX_IMAGE_WIDTH + 1);
    localparam int R_W   = ssdtm_pkg::ROW_W;
    localparam int IRW   = ssdtm_pkg::IMG_REG_W;
    localparam int TRW   = ssdtm_pkg::TPL_REG_W;
    localparam int ACC_W = ssdtm_pkg::SQ_W + $clog2(SIDE * SIDE) + 1;
    localparam int CH_W  = $clog2(SIDE + 2);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SWEEP, ST_READ, ST_SHIFT, ST_MAC, ST_DRAIN, ST_CHAIN, ST_OUT
    } state_t;

    state_t state_reg;

    logic [IRW-1:0]  img_w_reg, img_h_reg;
    logic [TRW-1:0]  tpl_w_reg, tpl_h_reg;
    logic [C_W-1:0]  col_reg;
    logic [R_W-1:0]  row_reg;
    logic [L_W-1:0]  lrow_reg;
    logic [TA_W-1:0] tpl_idx_reg;
    logic            dirty_reg;

    logic [C_W-1:0]  cur_col_reg;
    logic [L_W-1:0]  cur_lrow_reg;
    logic            emit_reg;

    logic [TA_W-1:0] sweep_k_reg;
    logic [L_W-1:0]  sweep_tx_reg, sweep_ty_reg;
    logic            tmpl_we_reg;
    logic [L_W-1:0]  tmpl_col_reg, tmpl_row_reg;
    logic [L_W-1:0]  mac_x_reg;
    logic [CH_W-1:0] chain_cnt_reg;

    logic [ssdtm_pkg::SCORE_W-1:0] m_score_reg;
    logic [ssdtm_pkg::POS_W-1:0]   m_win_row_reg, m_win_col_reg;
    logic                          m_last_reg;

    // Effective sizes after saturation
    logic [W_W-1:0]  w_eff;
    logic [IRW-1:0]  h_eff;
    logic [TS_W-1:0] tw_eff, th_eff;
    logic [N_W-1:0]  tpl_n;

    always_comb begin
        if (img_w_reg == '0) begin
            w_eff = W_W'(1);
        end else if (32'(img_w_reg) > 32'(MAX_IMAGE_WIDTH)) begin
            w_eff = W_W'(MAX_IMAGE_WIDTH);
        end else begin
            w_eff = W_W'(img_w_reg);
        end
        if (img_h_reg == '0) begin
            h_eff = IRW'(1);
        end else if (32'(img_h_reg) > 32'(ssdtm_pkg::MAX_IMAGE_HEIGHT)) begin
            h_eff = IRW'(ssdtm_pkg::MAX_IMAGE_HEIGHT);
        end else begin
            h_eff = img_h_reg;
        end
        if (tpl_w_reg == '0) begin
            tw_eff = TS_W'(1);
        end else if (32'(tpl_w_reg) > 32'(SIDE)) begin
            tw_eff = TS_W'(SIDE);
        end else begin
            tw_eff = TS_W'(tpl_w_reg);
        end
        if (tpl_h_reg == '0) begin
            th_eff = TS_W'(1);
        end else if (32'(tpl_h_reg) > 32'(SIDE)) begin
            th_eff = TS_W'(SIDE);
        end else begin
            th_eff = TS_W'(tpl_h_reg);
        end
        tpl_n = N_W'(32'(tw_eff) * 32'(th_eff));
    end

    // Position of the incoming image pixel, with counters wrapped to the frame
    logic            accept;
    logic            acc_img, acc_tpl;
    logic            row_wrap;
    logic [C_W-1:0]  c_use;
    logic [R_W-1:0]  r_use;
    logic [L_W-1:0]  lrow_use;
    logic [TA_W-1:0] idx_use;
    logic            emit_now, last_now;
    logic [31:0]     win_row_full, win_col_full;

    always_comb begin
        accept   = s_valid && s_ready;
        acc_img  = accept && (s_op == ssdtm_pkg::OP_IMAGE_PIXEL);
        acc_tpl  = accept && (s_op == ssdtm_pkg::OP_LOAD_TEMPLATE);
        c_use    = (32'(col_reg) >= 32'(w_eff)) ? '0 : col_reg;
        row_wrap = 32'(row_reg) >= 32'(h_eff);
        r_use    = row_wrap ? '0 : row_reg;
        lrow_use = row_wrap ? '0 : lrow_reg;
        idx_use  = (32'(tpl_idx_reg) >= 32'(tpl_n)) ? '0 : tpl_idx_reg;
        emit_now = (32'(r_use) + 32'd1 >= 32'(th_eff)) &&
                   (32'(c_use) + 32'd1 >= 32'(tw_eff));
        last_now = (32'(r_use) == 32'(h_eff) - 32'd1) &&
                   (32'(c_use) == 32'(w_eff) - 32'd1);
        win_row_full = 32'(r_use) + 32'd1 - 32'(th_eff);
        win_col_full = 32'(c_use) + 32'd1 - 32'(tw_eff);
    end

    // Memories
    logic [SIDE*PW-1:0] lb_word;
    logic [PW-1:0]      tmpl_rd_data;

    ssdtm_line_buf #(
        .SIDE  (SIDE),
        .MAX_W (MAX_IMAGE_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (acc_img),
        .wr_col  (c_use),
        .wr_lane (lrow_use),
        .wr_data (s_pixel),
        .rd_col  (cur_col_reg),
        .rd_word (lb_word)
    );

    ssdtm_tmpl_mem #(
        .SIDE (SIDE)
    ) u_tmpl_mem (
        .aclk    (aclk),
        .wr_en   (acc_tpl),
        .wr_addr (idx_use),
        .wr_data (s_pixel),
        .rd_addr (sweep_k_reg),
        .rd_data (tmpl_rd_data)
    );

    // Cell row with the score chain
    ssdtm_pkg::cell_ctrl_t cell_ctrl;
    logic [ACC_W-1:0]      acc_chain [SIDE+1];

    always_comb begin
        cell_ctrl.win_shift = (state_reg == ST_SHIFT);
        cell_ctrl.mac_clear = (state_reg == ST_SHIFT);
        cell_ctrl.mac_en    = (state_reg == ST_MAC);
        cell_ctrl.tmpl_we   = tmpl_we_reg;
    end

    assign acc_chain[0] = '0;

    for (genvar g = 0; g < SIDE; g++) begin : g_cell
        ssdtm_cell #(
            .SIDE     (SIDE),
            .CELL_IDX (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .lb_word   (lb_word),
            .lrow      (cur_lrow_reg),
            .tw        (tw_eff),
            .th        (th_eff),
            .tmpl_col  (tmpl_col_reg),
            .tmpl_row  (tmpl_row_reg),
            .tmpl_data (tmpl_rd_data),
            .mac_x     (mac_x_reg),
            .acc_in    (acc_chain[g]),
            .acc_out   (acc_chain[g+1])
        );
    end

    logic [ssdtm_pkg::SCORE_W-1:0] score_sat;

    always_comb begin
        if (acc_chain[SIDE] > ACC_W'(ssdtm_pkg::SCORE_MAX)) begin
            score_sat = ssdtm_pkg::SCORE_MAX;
        end else begin
            score_sat = ssdtm_pkg::SCORE_W'(acc_chain[SIDE]);
        end
    end

    // Sequencer, counters and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            img_w_reg     <= IRW'(1024);
            img_h_reg     <= IRW'(1024);
            tpl_w_reg     <= TRW'(16);
            tpl_h_reg     <= TRW'(16);
            col_reg       <= '0;
            row_reg       <= '0;
            lrow_reg      <= '0;
            tpl_idx_reg   <= '0;
            dirty_reg     <= 1'b1;
            tmpl_we_reg   <= 1'b0;
            sweep_k_reg   <= '0;
            sweep_tx_reg  <= '0;
            sweep_ty_reg  <= '0;
            mac_x_reg     <= '0;
            chain_cnt_reg <= '0;
            emit_reg      <= 1'b0;
        end else begin
            tmpl_we_reg <= 1'b0;

            // Register write restarts the frame and the template load
            if (cfg_wr_en) begin
                case (cfg_index)
                    ssdtm_pkg::REG_IMAGE_WIDTH:     img_w_reg <= cfg_wdata;
                    ssdtm_pkg::REG_IMAGE_HEIGHT:    img_h_reg <= cfg_wdata;
                    ssdtm_pkg::REG_TEMPLATE_WIDTH:  tpl_w_reg <= cfg_wdata[TRW-1:0];
                    ssdtm_pkg::REG_TEMPLATE_HEIGHT: tpl_h_reg <= cfg_wdata[TRW-1:0];
                    default: ;
                endcase
                col_reg     <= '0;
                row_reg     <= '0;
                lrow_reg    <= '0;
                tpl_idx_reg <= '0;
                dirty_reg   <= 1'b1;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (acc_tpl) begin
                        tpl_idx_reg <= (32'(idx_use) + 32'd1 >= 32'(tpl_n)) ?
                                       '0 : TA_W'(32'(idx_use) + 32'd1);
                        dirty_reg   <= 1'b1;
                    end else if (acc_img) begin
                        cur_col_reg   <= c_use;
                        cur_lrow_reg  <= lrow_use;
                        emit_reg      <= emit_now;
                        m_last_reg    <= last_now;
                        m_win_row_reg <= win_row_full[ssdtm_pkg::POS_W-1:0];
                        m_win_col_reg <= win_col_full[ssdtm_pkg::POS_W-1:0];
                        // Advance the raster position
                        if (32'(c_use) + 32'd1 >= 32'(w_eff)) begin
                            col_reg <= '0;
                            if (32'(r_use) + 32'd1 >= 32'(h_eff)) begin
                                row_reg  <= '0;
                                lrow_reg <= '0;
                            end else begin
                                row_reg  <= r_use + R_W'(1);
                                lrow_reg <= (32'(lrow_use) == 32'(SIDE - 1)) ?
                                            '0 : lrow_use + L_W'(1);
                            end
                        end else begin
                            col_reg <= c_use + C_W'(1);
                            row_reg <= r_use;
                            lrow_reg <= lrow_use;
                        end
                        sweep_k_reg  <= '0;
                        sweep_tx_reg <= '0;
                        sweep_ty_reg <= '0;
                        state_reg    <= dirty_reg ? ST_SWEEP : ST_READ;
                    end
                end
                ST_SWEEP: begin
                    // Copy the flat template store into the cells
                    tmpl_we_reg  <= 1'b1;
                    tmpl_col_reg <= sweep_tx_reg;
                    tmpl_row_reg <= sweep_ty_reg;
                    if (32'(sweep_k_reg) + 32'd1 >= 32'(tpl_n)) begin
                        dirty_reg <= 1'b0;
                        state_reg <= ST_READ;
                    end else begin
                        sweep_k_reg <= sweep_k_reg + TA_W'(1);
                        if (32'(sweep_tx_reg) + 32'd1 >= 32'(tw_eff)) begin
                            sweep_tx_reg <= '0;
                            sweep_ty_reg <= sweep_ty_reg + L_W'(1);
                        end else begin
                            sweep_tx_reg <= sweep_tx_reg + L_W'(1);
                        end
                    end
                end
                ST_READ: begin
                    state_reg <= ST_SHIFT;
                end
                ST_SHIFT: begin
                    mac_x_reg <= '0;
                    state_reg <= emit_reg ? ST_MAC : ST_IDLE;
                end
                ST_MAC: begin
                    if (32'(mac_x_reg) + 32'd1 >= 32'(tw_eff)) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        mac_x_reg <= mac_x_reg + L_W'(1);
                    end
                end
                ST_DRAIN: begin
                    chain_cnt_reg <= '0;
                    state_reg     <= ST_CHAIN;
                end
                ST_CHAIN: begin
                    // Hold until the sum has rippled through every cell
                    if (32'(chain_cnt_reg) == 32'(SIDE)) begin
                        m_score_reg <= score_sat;
                        state_reg   <= ST_OUT;
                    end else begin
                        chain_cnt_reg <= chain_cnt_reg + CH_W'(1);
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign m_score   = m_score_reg;
    assign m_win_row = m_win_row_reg;
    assign m_win_col = m_win_col_reg;
    assign m_last    = m_last_reg;

endmodule

`default_nettype wire
